// ===== rtl/core/sme_pkg.sv =====
// shared types, widths and constants of the stereo mixer
package sme_pkg;

    // field widths
    localparam int CH_W     = 8;
    localparam int SAMPLE_W = 16;
    localparam int CFG_W    = 8;
    localparam int IDX_W    = 3;
    localparam int LEVEL_W  = 3;
    localparam int MODE_W   = 3;

    // internal datapath widths
    localparam int SUM_W    = CH_W + 2;
    localparam int GAIN_W   = 11;
    localparam int VAL_W    = 22;
    localparam int ACC_W    = 20;
    localparam int MUL_A_W  = VAL_W;
    localparam int MUL_B_W  = 21;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;

    // gain factors
    localparam int GAIN_DIGITAL = 256;
    localparam int GAIN_ANALOG  = 60;

    // divide by 14 as multiply by reciprocal, exact for |acc| below 2^19
    localparam int DIV14_MUL   = 599187;
    localparam int DIV14_SHIFT = 23;

    // saturation limits
    localparam int SAMPLE_MAX = 32767;
    localparam int SAMPLE_MIN = -32768;

    localparam int ECHO_DEPTH_DEF = 4000;

    // volume mode codes
    localparam logic [MODE_W-1:0] VOL_SHIFT2 = 3'd4;
    localparam logic [MODE_W-1:0] VOL_SHIFT1 = 3'd5;

    // configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_ROUTE        = 3'd0,
        REG_FIRST_LEVEL  = 3'd1,
        REG_SECOND_LEVEL = 3'd2,
        REG_ECHO_EN      = 3'd3,
        REG_LOWPASS_EN   = 3'd4,
        REG_VOLUME       = 3'd5,
        REG_SWAP         = 3'd6
    } reg_idx_t;

    // echo store control from the sequencer
    typedef struct packed {
        logic rd;
        logic wr;
    } echo_ctrl_t;

    // saturate a wide value to a 16-bit sample
    function automatic logic signed [SAMPLE_W-1:0] clamp_sample(
        input logic signed [PROD_W-1:0] x
    );
        logic signed [PROD_W-1:0] hi;
        logic signed [PROD_W-1:0] lo;
        hi = PROD_W'(SAMPLE_MAX);
        lo = PROD_W'(SAMPLE_MIN);
        if (x > hi)
        begin
            clamp_sample = SAMPLE_W'(SAMPLE_MAX);
        end
        else if (x < lo)
        begin
            clamp_sample = SAMPLE_W'(SAMPLE_MIN);
        end
        else
        begin
            clamp_sample = x[SAMPLE_W-1:0];
        end
    endfunction

endpackage

// ===== rtl/core/sme_mul.sv =====
// shared signed multiplier with registered product
module sme_mul (
    input  logic                                clk,
    input  logic signed [sme_pkg::MUL_A_W-1:0] a,
    input  logic signed [sme_pkg::MUL_B_W-1:0] b,
    output logic signed [sme_pkg::PROD_W-1:0]  p
);
    import sme_pkg::*;

    logic signed [PROD_W-1:0] p_reg;

    // one product per cycle
    always_ff @(posedge clk)
    begin
        p_reg <= PROD_W'(a) * PROD_W'(b);
    end

    assign p = p_reg;

endmodule

// ===== rtl/core/sme_echo_mem.sv =====
// circular echo store with write position and first-pass tracking
module sme_echo_mem #(
    parameter int ECHO_DEPTH = sme_pkg::ECHO_DEPTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  sme_pkg::echo_ctrl_t                  ctrl,
    input  logic        [sme_pkg::SAMPLE_W-1:0]  wr_data,
    output logic signed [sme_pkg::SAMPLE_W-1:0]  rd_data
);
    import sme_pkg::*;

    localparam int POS_W = $clog2(ECHO_DEPTH);

    logic [SAMPLE_W-1:0] mem [ECHO_DEPTH];
    logic [SAMPLE_W-1:0] rd_data_reg;
    logic                rd_hit_reg;
    logic [POS_W-1:0]    pos_reg;
    logic [POS_W-1:0]    pos_next;
    logic                wrapped_reg;
    logic                wrapped_next;

    // position advance and wrap, entries ahead of the position are unwritten until first wrap
    always_comb
    begin
        pos_next     = pos_reg;
        wrapped_next = wrapped_reg;
        if (ctrl.wr)
        begin
            if (pos_reg == POS_W'(ECHO_DEPTH - 1))
            begin
                pos_next     = '0;
                wrapped_next = 1'b1;
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            wrapped_reg <= 1'b0;
            rd_hit_reg  <= 1'b0;
        end
        else
        begin
            pos_reg     <= pos_next;
            wrapped_reg <= wrapped_next;
            if (ctrl.rd)
            begin
                rd_hit_reg <= wrapped_reg;
            end
        end
    end

    // store array, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (ctrl.wr)
        begin
            mem[pos_reg] <= wr_data;
        end
        if (ctrl.rd)
        begin
            rd_data_reg <= mem[pos_reg];
        end
    end

    // never-written entry reads as zero
    assign rd_data = rd_hit_reg ? $signed(rd_data_reg) : '0;

endmodule

// ===== rtl/core/stereo_mixer_echo_lowpass.sv =====
// stereo mixer top: config registers, sequencer, lowpass taps and output register
// each output takes 4 to 6 sequencer steps; an item is taken only when idle, after the
//   previous result is loaded into the output register, and the shared multiplier does
//   the gain, divide-by-14 and volume products one after another for each output
// reset: config to defaults, taps cleared, echo store reads zero until written,
//   no clearing pass, input ready right after reset
module stereo_mixer_echo_lowpass #(
    parameter int ECHO_DEPTH = sme_pkg::ECHO_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write port
    input  logic                                cfg_we,
    input  logic        [sme_pkg::IDX_W-1:0]    cfg_idx,
    input  logic        [sme_pkg::CFG_W-1:0]    cfg_data,
    // input channel
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [sme_pkg::CH_W-1:0]     chan_a_sample,
    input  logic signed [sme_pkg::CH_W-1:0]     chan_b_sample,
    input  logic signed [sme_pkg::CH_W-1:0]     chan_c_sample,
    input  logic signed [sme_pkg::CH_W-1:0]     chan_d_sample,
    input  logic                                digital_mode,
    // output channel
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [sme_pkg::SAMPLE_W-1:0] first_sample,
    output logic signed [sme_pkg::SAMPLE_W-1:0] second_sample
);
    import sme_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_SUM  = 8'b0000_0010,
        S_ECHO = 8'b0000_0100,
        S_LP   = 8'b0000_1000,
        S_DIV  = 8'b0001_0000,
        S_VOL  = 8'b0010_0000,
        S_VOLW = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } state_t;

    // configuration registers
    logic [CFG_W-1:0]   route_mask_reg;
    logic [LEVEL_W-1:0] first_level_reg;
    logic [LEVEL_W-1:0] second_level_reg;
    logic               echo_enable_reg;
    logic               lowpass_enable_reg;
    logic [MODE_W-1:0]  volume_mode_reg;
    logic               swap_outputs_reg;

    // sequencer and datapath registers
    state_t                    state_reg, state_next;
    logic                      sel_reg, sel_next;
    logic                      neg_reg, neg_next;
    logic signed [VAL_W-1:0]   val_reg, val_next;
    logic signed [CH_W-1:0]    ch_reg [4];
    logic                      digital_reg;
    logic signed [SAMPLE_W-1:0] res_reg [2];
    logic signed [SAMPLE_W-1:0] res_next;
    logic                      res_we;
    logic signed [SAMPLE_W-1:0] taps_reg [2][4];
    logic                      taps_we;
    logic                      out_valid_reg, out_valid_next;
    logic signed [SAMPLE_W-1:0] first_sample_reg;
    logic signed [SAMPLE_W-1:0] second_sample_reg;
    logic                      out_load;
    logic                      in_accept;

    // shared multiplier operands
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod;

    // echo store port
    echo_ctrl_t                echo_ctrl;
    logic        [SAMPLE_W-1:0] echo_wr_data;
    logic signed [SAMPLE_W-1:0] echo_rd_data;

    // combinational datapath pieces
    logic [3:0]                mask;
    logic [LEVEL_W-1:0]        level;
    logic signed [SUM_W-1:0]   sum;
    logic [GAIN_W-1:0]         gain;
    logic signed [VAL_W-1:0]   prod_v;
    logic signed [VAL_W:0]     echo_t;
    logic signed [VAL_W:0]     echo_r;
    logic signed [VAL_W-1:0]   echo_avg;
    logic signed [ACC_W-1:0]   acc;
    logic signed [ACC_W-1:0]   acc_abs;
    logic signed [VAL_W-1:0]   quo;

    sme_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    sme_echo_mem #(
        .ECHO_DEPTH (ECHO_DEPTH)
    ) u_echo (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (echo_ctrl),
        .wr_data (echo_wr_data),
        .rd_data (echo_rd_data)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign in_accept = in_valid && in_ready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            route_mask_reg     <= '0;
            first_level_reg    <= LEVEL_W'(7);
            second_level_reg   <= LEVEL_W'(7);
            echo_enable_reg    <= 1'b0;
            lowpass_enable_reg <= 1'b0;
            volume_mode_reg    <= '0;
            swap_outputs_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_ROUTE:        route_mask_reg     <= cfg_data;
                REG_FIRST_LEVEL:  first_level_reg    <= cfg_data[LEVEL_W-1:0];
                REG_SECOND_LEVEL: second_level_reg   <= cfg_data[LEVEL_W-1:0];
                REG_ECHO_EN:      echo_enable_reg    <= cfg_data[0];
                REG_LOWPASS_EN:   lowpass_enable_reg <= cfg_data[0];
                REG_VOLUME:       volume_mode_reg    <= cfg_data[MODE_W-1:0];
                REG_SWAP:         swap_outputs_reg   <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // channel sum and gain for the output in progress
    always_comb
    begin
        mask  = sel_reg ? route_mask_reg[3:0] : route_mask_reg[7:4];
        level = sel_reg ? second_level_reg : first_level_reg;
        sum   = '0;
        for (int i = 0; i < 4; i++)
        begin
            if (mask[i])
            begin
                sum = sum + SUM_W'(ch_reg[i]);
            end
        end
        gain = digital_reg ? GAIN_W'(GAIN_W'(level) * GAIN_W'(GAIN_DIGITAL))
                           : GAIN_W'(GAIN_W'(level) * GAIN_W'(GAIN_ANALOG));
    end

    // echo average, truncating toward zero
    always_comb
    begin
        prod_v   = VAL_W'(prod);
        echo_t   = $signed({prod_v, 1'b0}) + (VAL_W + 1)'(echo_rd_data);
        echo_r   = echo_t + $signed({{VAL_W{1'b0}}, echo_t[VAL_W]});
        echo_avg = VAL_W'(echo_r >>> 1);
    end

    // lowpass accumulator over the selected taps
    always_comb
    begin
        acc = ACC_W'(taps_reg[sel_reg][3])
            + (ACC_W'(taps_reg[sel_reg][2]) <<< 1)
            + (ACC_W'(taps_reg[sel_reg][1]) <<< 3)
            + (ACC_W'(taps_reg[sel_reg][0]) <<< 1)
            + ACC_W'($signed(val_reg[SAMPLE_W-1:0]));
        acc_abs = acc[ACC_W-1] ? -acc : acc;
        quo     = VAL_W'(prod >>> DIV14_SHIFT);
    end

    // multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_SUM:
            begin
                mul_a = MUL_A_W'(sum);
                mul_b = $signed({{(MUL_B_W - GAIN_W){1'b0}}, gain});
            end
            S_LP:
            begin
                mul_a = $signed({{(MUL_A_W - ACC_W){1'b0}}, acc_abs});
                mul_b = MUL_B_W'(DIV14_MUL);
            end
            S_VOL:
            begin
                mul_a = val_reg;
                mul_b = $signed(MUL_B_W'({1'b0, volume_mode_reg[1:0]} + 3'd1));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        sel_next       = sel_reg;
        neg_next       = neg_reg;
        val_next       = val_reg;
        res_we         = 1'b0;
        res_next       = '0;
        taps_we        = 1'b0;
        echo_ctrl      = '0;
        echo_wr_data   = echo_avg[SAMPLE_W-1:0];
        out_load       = 1'b0;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    sel_next   = 1'b0;
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                echo_ctrl.rd = 1'b1;
                state_next   = S_ECHO;
            end
            S_ECHO:
            begin
                if (echo_enable_reg)
                begin
                    echo_ctrl.wr = 1'b1;
                    val_next     = echo_avg;
                end
                else
                begin
                    val_next = prod_v;
                end
                state_next = S_LP;
            end
            S_LP:
            begin
                if (lowpass_enable_reg)
                begin
                    taps_we    = 1'b1;
                    neg_next   = acc[ACC_W-1];
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_VOL;
                end
            end
            S_DIV:
            begin
                val_next   = neg_reg ? -quo : quo;
                state_next = S_VOL;
            end
            S_VOL:
            begin
                if (volume_mode_reg < VOL_SHIFT2)
                begin
                    state_next = S_VOLW;
                end
                else
                begin
                    res_we = 1'b1;
                    if (volume_mode_reg == VOL_SHIFT2)
                    begin
                        res_next = clamp_sample(PROD_W'(val_reg >>> 2));
                    end
                    else if (volume_mode_reg == VOL_SHIFT1)
                    begin
                        res_next = clamp_sample(PROD_W'(val_reg >>> 1));
                    end
                    else
                    begin
                        res_next = clamp_sample(PROD_W'(val_reg));
                    end
                    sel_next   = 1'b1;
                    state_next = sel_reg ? S_DONE : S_SUM;
                end
            end
            S_VOLW:
            begin
                res_we     = 1'b1;
                res_next   = clamp_sample(prod);
                sel_next   = 1'b1;
                state_next = sel_reg ? S_DONE : S_SUM;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sel_reg       <= 1'b0;
            neg_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            neg_reg       <= neg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // lowpass taps, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 2; k++)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    taps_reg[k][j] <= '0;
                end
            end
        end
        else if (taps_we)
        begin
            taps_reg[sel_reg][3] <= taps_reg[sel_reg][2];
            taps_reg[sel_reg][2] <= taps_reg[sel_reg][1];
            taps_reg[sel_reg][1] <= taps_reg[sel_reg][0];
            taps_reg[sel_reg][0] <= $signed(val_reg[SAMPLE_W-1:0]);
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        if (in_accept)
        begin
            ch_reg[0]   <= chan_a_sample;
            ch_reg[1]   <= chan_b_sample;
            ch_reg[2]   <= chan_c_sample;
            ch_reg[3]   <= chan_d_sample;
            digital_reg <= digital_mode;
        end
        if (res_we)
        begin
            res_reg[sel_reg] <= res_next;
        end
        if (out_load)
        begin
            first_sample_reg  <= swap_outputs_reg ? res_reg[1] : res_reg[0];
            second_sample_reg <= swap_outputs_reg ? res_reg[0] : res_reg[1];
        end
    end

    assign out_valid     = out_valid_reg;
    assign first_sample  = first_sample_reg;
    assign second_sample = second_sample_reg;

endmodule

// ===== test/tb_top.sv =====
// self-checking testbench of the stereo mixer with echo, lowpass, volume and swap
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sme_pkg::*;

    localparam int ECHO_LEN     = ECHO_DEPTH_DEF;
    localparam int RUN_LIMIT    = 500000;
    localparam int SETTLE_CYCLES = 20;
    localparam int LP_DIVISOR   = 14;
    localparam int VOL_MODES    = 8;
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_ITEMS  = 250;
    localparam int HOLD_CYCLES  = 300;

    // volume mode codes not named in the package
    localparam logic [MODE_W-1:0] VOL_X1     = 3'd0;
    localparam logic [MODE_W-1:0] VOL_PASS_A = 3'd6;
    localparam logic [MODE_W-1:0] VOL_PASS_B = 3'd7;

    typedef struct {
        logic signed [CH_W-1:0] chan_a;
        logic signed [CH_W-1:0] chan_b;
        logic signed [CH_W-1:0] chan_c;
        logic signed [CH_W-1:0] chan_d;
        logic                   digital;
    } mix_item_t;

    typedef struct {
        logic signed [SAMPLE_W-1:0] first;
        logic signed [SAMPLE_W-1:0] second;
    } mix_result_t;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       cfg_we;
    logic        [IDX_W-1:0]    cfg_idx;
    logic        [CFG_W-1:0]    cfg_data;
    logic                       in_valid;
    logic                       in_ready;
    logic signed [CH_W-1:0]     chan_a_sample;
    logic signed [CH_W-1:0]     chan_b_sample;
    logic signed [CH_W-1:0]     chan_c_sample;
    logic signed [CH_W-1:0]     chan_d_sample;
    logic                       digital_mode;
    logic                       out_valid;
    logic                       out_ready;
    logic signed [SAMPLE_W-1:0] first_sample;
    logic signed [SAMPLE_W-1:0] second_sample;

    // register copies
    logic [7:0]        cfg_route;
    logic [LEVEL_W-1:0] cfg_first_level;
    logic [LEVEL_W-1:0] cfg_second_level;
    logic              cfg_echo_en;
    logic              cfg_lowpass_en;
    logic [MODE_W-1:0] cfg_volume;
    logic              cfg_swap;

    // mixer state copies
    logic signed [SAMPLE_W-1:0] echo_mem [ECHO_LEN];
    int                         echo_pos;
    logic signed [SAMPLE_W-1:0] lp_taps [2][4];

    mix_result_t mixed_expected[$];

    int tx_idle_pct;
    int rx_stall_pct;
    int rx_hold_request;
    int rx_hold_left;
    int cycle_count;
    int fail_count;
    int items_sent;
    int results_seen;
    int echo_wraps;

    stereo_mixer_echo_lowpass #(
        .ECHO_DEPTH(ECHO_LEN)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_idx       (cfg_idx),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .chan_a_sample (chan_a_sample),
        .chan_b_sample (chan_b_sample),
        .chan_c_sample (chan_c_sample),
        .chan_d_sample (chan_d_sample),
        .digital_mode  (digital_mode),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .first_sample  (first_sample),
        .second_sample (second_sample)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver: random stalls plus a long hold-off on request
    always @(posedge clk)
    begin
        if (rx_hold_request > 0)
        begin
            rx_hold_left = rx_hold_request;
            rx_hold_request = 0;
        end
        if (rx_hold_left > 0)
        begin
            rx_hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // compare each accepted result with the oldest expected one
    always @(posedge clk)
    begin
        mix_result_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (mixed_expected.size() == 0)
            begin
                $error("unexpected result first_sample %0d second_sample %0d",
                       first_sample, second_sample);
                fail_count++;
            end
            else
            begin
                exp_r = mixed_expected.pop_front();
                if (first_sample !== exp_r.first)
                begin
                    $error("first_sample expected %0d got %0d", exp_r.first, first_sample);
                    fail_count++;
                end
                if (second_sample !== exp_r.second)
                begin
                    $error("second_sample expected %0d got %0d", exp_r.second,
                           second_sample);
                    fail_count++;
                end
            end
        end
    end

    // one output of the mix: route, gain, echo, lowpass, volume, clamp
    function automatic int mix_channel(input mix_item_t it, input int side);
        int                         v;
        int                         c;
        int                         acc;
        logic [3:0]                 sel;
        logic [LEVEL_W-1:0]         lvl;
        logic signed [SAMPLE_W-1:0] low16;
        sel = (side == 0) ? cfg_route[7:4] : cfg_route[3:0];
        lvl = (side == 0) ? cfg_first_level : cfg_second_level;
        v = 0;
        if (sel[0]) v += it.chan_a;
        if (sel[1]) v += it.chan_b;
        if (sel[2]) v += it.chan_c;
        if (sel[3]) v += it.chan_d;
        v = v * int'(lvl) * (it.digital ? GAIN_DIGITAL : GAIN_ANALOG);
        // echo: average with the circular store, full width carries on
        if (cfg_echo_en)
        begin
            v = (v * 2 + echo_mem[echo_pos]) / 2;
            echo_mem[echo_pos] = v[SAMPLE_W-1:0];
            if (echo_pos == ECHO_LEN - 1)
            begin
                echo_pos = 0;
                echo_wraps++;
            end
            else
            begin
                echo_pos++;
            end
        end
        // five-tap lowpass on the low 16 bits
        if (cfg_lowpass_en)
        begin
            low16 = v[SAMPLE_W-1:0];
            c = low16;
            acc = lp_taps[side][3] + 2 * lp_taps[side][2] + 8 * lp_taps[side][1]
                  + 2 * lp_taps[side][0] + c;
            lp_taps[side][3] = lp_taps[side][2];
            lp_taps[side][2] = lp_taps[side][1];
            lp_taps[side][1] = lp_taps[side][0];
            lp_taps[side][0] = low16;
            v = acc / LP_DIVISOR;
        end
        // volume, shifts round toward minus infinity
        case (cfg_volume)
            VOL_SHIFT2: v = v >>> 2;
            VOL_SHIFT1: v = v >>> 1;
            VOL_PASS_A, VOL_PASS_B: v = v;
            default: v = v * (int'(cfg_volume) + 1);
        endcase
        if (v > SAMPLE_MAX) v = SAMPLE_MAX;
        if (v < SAMPLE_MIN) v = SAMPLE_MIN;
        return v;
    endfunction

    function automatic mix_result_t predict_mix(input mix_item_t it);
        int          a;
        int          b;
        mix_result_t r;
        a = mix_channel(it, 0);
        b = mix_channel(it, 1);
        r.first  = cfg_swap ? SAMPLE_W'(b) : SAMPLE_W'(a);
        r.second = cfg_swap ? SAMPLE_W'(a) : SAMPLE_W'(b);
        return r;
    endfunction

    function automatic logic signed [CH_W-1:0] random_chan();
        int pick;
        pick = $urandom_range(0, 19);
        case (pick)
            0: return -8'sd128;
            1: return 8'sd127;
            2: return 8'sd0;
            3: return -8'sd1;
            default: return CH_W'($urandom);
        endcase
    endfunction

    function automatic mix_item_t random_item();
        mix_item_t it;
        it.chan_a  = random_chan();
        it.chan_b  = random_chan();
        it.chan_c  = random_chan();
        it.chan_d  = random_chan();
        it.digital = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic mix_item_t make_item(input int a, input int b, input int c,
                                            input int d, input logic dig);
        mix_item_t it;
        it.chan_a  = CH_W'(a);
        it.chan_b  = CH_W'(b);
        it.chan_c  = CH_W'(c);
        it.chan_d  = CH_W'(d);
        it.digital = dig;
        return it;
    endfunction

    // register write, also applied to the local copy
    task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        case (idx)
            REG_ROUTE:        cfg_route        = data;
            REG_FIRST_LEVEL:  cfg_first_level  = data[LEVEL_W-1:0];
            REG_SECOND_LEVEL: cfg_second_level = data[LEVEL_W-1:0];
            REG_ECHO_EN:      cfg_echo_en      = data[0];
            REG_LOWPASS_EN:   cfg_lowpass_en   = data[0];
            REG_VOLUME:       cfg_volume       = data[MODE_W-1:0];
            REG_SWAP:         cfg_swap         = data[0];
            default:          ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // offer one item after a random gap and wait until it is taken
    task automatic send_item(input mix_item_t it);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < tx_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        chan_a_sample <= it.chan_a;
        chan_b_sample <= it.chan_b;
        chan_c_sample <= it.chan_c;
        chan_d_sample <= it.chan_d;
        digital_mode  <= it.digital;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        mixed_expected.push_back(predict_mix(it));
        items_sent++;
    endtask

    // stop offering and wait for every expected result
    task automatic finish_burst();
        in_valid <= 1'b0;
        while (mixed_expected.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_idling(input int tx_pct, input int rx_pct);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
    endtask

    // reset values: nothing routed, both outputs silent
    task automatic test_reset_values();
        send_item(make_item(127, -128, 55, -7, 1'b1));
        send_item(make_item(-1, 1, -128, 127, 1'b0));
        finish_burst();
    endtask

    // field extremes with full routing, clamping both ways
    task automatic test_field_extremes();
        write_reg(REG_ROUTE, 8'hFF);
        write_reg(REG_FIRST_LEVEL, 8'd7);
        write_reg(REG_SECOND_LEVEL, 8'd7);
        send_item(make_item(127, 127, 127, 127, 1'b1));
        send_item(make_item(-128, -128, -128, -128, 1'b1));
        send_item(make_item(127, -128, 0, 1, 1'b0));
        send_item(make_item(0, 0, 0, 0, 1'b0));
        finish_burst();
    endtask

    // every volume mode, lowpass on so shifts see odd negative values
    task automatic test_volume_modes();
        write_reg(REG_ROUTE, 8'hA5);
        write_reg(REG_FIRST_LEVEL, 8'd3);
        write_reg(REG_SECOND_LEVEL, 8'd5);
        write_reg(REG_LOWPASS_EN, 8'd1);
        for (int m = 0; m < VOL_MODES; m++)
        begin
            write_reg(REG_VOLUME, CFG_W'(m));
            send_item(make_item(-3 - m, 7 * m - 20, 11 - 5 * m, -1 - 2 * m, m[0]));
            finish_burst();
        end
    endtask

    // echo store on, then off so the store and position hold
    task automatic test_echo_store();
        write_reg(REG_LOWPASS_EN, 8'd0);
        write_reg(REG_VOLUME, 8'(VOL_PASS_A));
        write_reg(REG_ROUTE, 8'h3C);
        write_reg(REG_FIRST_LEVEL, 8'd1);
        write_reg(REG_SECOND_LEVEL, 8'd2);
        write_reg(REG_ECHO_EN, 8'd1);
        send_item(make_item(-77, 33, -5, 99, 1'b0));
        send_item(make_item(12, -128, 127, -3, 1'b1));
        send_item(make_item(-1, -1, -1, -1, 1'b0));
        finish_burst();
        write_reg(REG_ECHO_EN, 8'd0);
        send_item(make_item(64, -64, 32, -32, 1'b1));
        finish_burst();
    endtask

    // echo and lowpass together with swapped outputs
    task automatic test_lowpass_swap();
        write_reg(REG_ECHO_EN, 8'd1);
        write_reg(REG_LOWPASS_EN, 8'd1);
        write_reg(REG_SWAP, 8'd1);
        write_reg(REG_VOLUME, 8'(VOL_SHIFT1));
        write_reg(REG_ROUTE, 8'h96);
        for (int i = 0; i < 5; i++)
            send_item(random_item());
        finish_burst();
    endtask

    // receiver holds off long while the sender keeps offering items
    task automatic test_backpressure();
        set_idling(0, 0);
        rx_hold_request = HOLD_CYCLES;
        for (int i = 0; i < 30; i++)
            send_item(random_item());
        finish_burst();
    endtask

    // random items over several settings and idling mixes, echo kept on
    task automatic test_random_phases();
        logic [CFG_W-1:0] route_v;
        logic [CFG_W-1:0] first_v;
        logic [CFG_W-1:0] second_v;
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            route_v  = (p == 0) ? 8'hFF : (p == 1) ? 8'h00 : CFG_W'($urandom);
            first_v  = (p == 0) ? 8'hFF : (p == 1) ? 8'h00 : CFG_W'($urandom);
            second_v = (p == 0) ? 8'hFF : (p == 1) ? 8'h00 : CFG_W'($urandom);
            write_reg(REG_ROUTE, route_v);
            write_reg(REG_FIRST_LEVEL, first_v);
            write_reg(REG_SECOND_LEVEL, second_v);
            write_reg(REG_ECHO_EN, CFG_W'($urandom) | 8'd1);
            write_reg(REG_LOWPASS_EN, CFG_W'(p[0]) | (CFG_W'($urandom) & 8'hFE));
            write_reg(REG_VOLUME, CFG_W'(p) | (CFG_W'($urandom) & 8'hF8));
            write_reg(REG_SWAP, CFG_W'(p[1]));
            case (p % 4)
                0: set_idling(0, 0);
                1: set_idling(61, 0);
                2: set_idling(0, 61);
                default: set_idling(31, 31);
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_item(random_item());
            finish_burst();
        end
    endtask

    initial
    begin
        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_idx         <= REG_ROUTE;
        cfg_data        <= '0;
        in_valid        <= 1'b0;
        chan_a_sample   <= '0;
        chan_b_sample   <= '0;
        chan_c_sample   <= '0;
        chan_d_sample   <= '0;
        digital_mode    <= 1'b0;
        out_ready       <= 1'b0;
        rx_hold_request = 0;
        rx_hold_left    = 0;
        cycle_count     = 0;
        fail_count      = 0;
        items_sent      = 0;
        results_seen    = 0;
        echo_wraps      = 0;
        set_idling(0, 0);

        // state after reset
        cfg_route        = '0;
        cfg_first_level  = 3'd7;
        cfg_second_level = 3'd7;
        cfg_echo_en      = 1'b0;
        cfg_lowpass_en   = 1'b0;
        cfg_volume       = VOL_X1;
        cfg_swap         = 1'b0;
        foreach (echo_mem[i])
            echo_mem[i] = '0;
        echo_pos = 0;
        foreach (lp_taps[s, t])
            lp_taps[s][t] = '0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_field_extremes();
        test_volume_modes();
        test_echo_store();
        test_lowpass_swap();
        test_random_phases();
        test_backpressure();

        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("covered %0d items and %0d results: all volume modes, echo, lowpass,",
                 items_sent, results_seen);
        $display("swap, clamping, idling mixes and a %0d-cycle hold-off;",
                 HOLD_CYCLES);
        $display("echo store wrapped %0d times", echo_wraps);
        if (fail_count == 0 && mixed_expected.size() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
